// File: design/fbef_pkg.sv
package fbef_pkg;

    localparam int QUEUE_DEPTH  = 64;
    localparam int BUTTON_COUNT = 13;
    localparam int PTR_W        = $clog2(QUEUE_DEPTH);
    localparam int CNT_W        = PTR_W + 1;
    localparam int CODE_W       = 6;
    localparam int BTN_W        = 4;
    localparam int STATE_W      = 2;
    localparam int LIMIT_W      = 8;
    localparam int OP_W         = 2;
    localparam int MASK_W       = 4 * BUTTON_COUNT;

    localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
    localparam logic [OP_W-1:0] OP_POP   = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

    localparam logic [CODE_W-1:0] CODE_EMPTY    = 6'd0;
    localparam logic [CODE_W-1:0] CODE_OVERFLOW = 6'd1;

    // Broadcast to every cell of the queue
    typedef struct packed {
        logic              shift;
        logic              load;
        logic [PTR_W-1:0]  load_pos;
        logic [CODE_W-1:0] load_code;
    } t_cell_ctl;

endpackage

// File: design/fbef_cell.sv
module fbef_cell (
    input  logic                        i_clk,
    input  fbef_pkg::t_cell_ctl         i_ctl,
    input  logic [fbef_pkg::PTR_W-1:0]  i_cell_idx,
    input  logic [fbef_pkg::CODE_W-1:0] i_next_code,
    output logic [fbef_pkg::CODE_W-1:0] o_code
);
    import fbef_pkg::*;

    logic [CODE_W-1:0] r_code;
    logic [CODE_W-1:0] n_code;

    // Pop moves the whole row one place towards the head; push loads the addressed cell
    always_comb begin
        n_code = r_code;
        if (i_ctl.shift) begin
            n_code = i_next_code;
        end else if (i_ctl.load && (i_ctl.load_pos == i_cell_idx)) begin
            n_code = i_ctl.load_code;
        end
    end

    always_ff @(posedge i_clk) begin
        r_code <= n_code;
    end

    assign o_code = r_code;

endmodule

// File: design/filtered_button_event_fifo.sv
// Filtered button event queue.
// Input channel (i_in_valid / o_in_stall) carries one operation per item:
// push an event (button index, event state), pop the oldest event, or query
// the fill count clipped to i_max_count. A push is kept only if the button's
// interest bit for that state is set in the event mask.
// Output channel (o_out_valid / i_out_stall) returns one item per input item:
// the popped code (0 on empty or for non-pop operations) and the fill count.
// o_out_valid rises in the cycle after acceptance; one item per cycle is
// sustained while the output is taken. The queue is a row of 64 cells with
// the oldest entry at the head; a pop shifts every cell one place in the same
// cycle, a push loads the cell at the fill position.
// The event mask is written through i_cfg_valid / o_cfg_ready / i_cfg_data
// (always ready) and must be written only while the block is idle.
// Reset (synchronous, active low) empties the queue and clears the mask; no
// clearing pass is needed, so items are accepted from the first cycle after.
// While the receiver stalls a waiting result, o_in_stall is raised and the
// result holds.
module filtered_button_event_fifo (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [fbef_pkg::OP_W-1:0]    i_op,
    input  logic [fbef_pkg::BTN_W-1:0]   i_button_index,
    input  logic [fbef_pkg::STATE_W-1:0] i_event_state,
    input  logic [fbef_pkg::LIMIT_W-1:0] i_max_count,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [fbef_pkg::CODE_W-1:0]  o_event_code,
    output logic [fbef_pkg::CNT_W-1:0]   o_count,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [fbef_pkg::MASK_W-1:0]  i_cfg_data
);
    import fbef_pkg::*;

    logic [MASK_W-1:0] r_mask;
    logic [CNT_W-1:0]  r_fill;
    logic [CNT_W-1:0]  n_fill;
    logic              r_out_valid;
    logic [CODE_W-1:0] r_event_code;
    logic [CNT_W-1:0]  r_count;

    logic              accept;
    logic              btn_ok;
    logic              hit;
    logic              full;
    logic              do_push;
    logic              do_pop;
    logic [BTN_W+STATE_W-1:0] mask_idx;
    logic [BTN_W-1:0]  btn_plus;
    t_cell_ctl         cell_ctl;
    logic [CODE_W-1:0] cell_code [QUEUE_DEPTH];

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_out_valid & i_out_stall;
    assign accept      = i_in_valid & ~o_in_stall;

    assign mask_idx = {i_button_index, i_event_state};
    assign btn_ok   = 32'(i_button_index) < BUTTON_COUNT;
    assign hit      = btn_ok && r_mask[btn_ok ? mask_idx : '0];
    assign full     = (r_fill == CNT_W'(QUEUE_DEPTH));
    assign do_push  = accept && (i_op == OP_PUSH) && hit;
    assign do_pop   = accept && (i_op == OP_POP) && (r_fill != '0);
    assign btn_plus = BTN_W'(i_button_index + 4'd1);

    // When full, overwrite the newest entry with the overflow code
    always_comb begin
        cell_ctl.shift     = do_pop;
        cell_ctl.load      = do_push;
        cell_ctl.load_pos  = full ? PTR_W'(QUEUE_DEPTH - 1) : r_fill[PTR_W-1:0];
        cell_ctl.load_code = full ? CODE_OVERFLOW : {btn_plus, i_event_state};
    end

    always_comb begin
        n_fill = r_fill;
        if (do_push && !full) begin
            n_fill = CNT_W'(r_fill + 1'b1);
        end else if (do_pop) begin
            n_fill = CNT_W'(r_fill - 1'b1);
        end
    end

    genvar g;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
            logic [CODE_W-1:0] next_code;
            if (g == QUEUE_DEPTH - 1) begin : g_tail
                assign next_code = cell_code[g];
            end else begin : g_body
                assign next_code = cell_code[g + 1];
            end
            fbef_cell u_cell (
                .i_clk       (i_clk),
                .i_ctl       (cell_ctl),
                .i_cell_idx  (PTR_W'(g)),
                .i_next_code (next_code),
                .o_code      (cell_code[g])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask      <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_mask <= i_cfg_data;
            end
            r_fill <= n_fill;
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload: hold while stalled
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_event_code <= do_pop ? cell_code[0] : CODE_EMPTY;
            if ((i_op == OP_QUERY) && (32'(n_fill) > 32'(i_max_count))) begin
                r_count <= CNT_W'(i_max_count);
            end else begin
                r_count <= n_fill;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_event_code = r_event_code;
    assign o_count      = r_count;

endmodule

// File: design/fbef_checker.sv
module fbef_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         o_in_stall,
    input logic [fbef_pkg::OP_W-1:0]    i_op,
    input logic [fbef_pkg::LIMIT_W-1:0] i_max_count,
    input logic                         o_out_valid,
    input logic                         i_out_stall,
    input logic [fbef_pkg::CODE_W-1:0]  o_event_code,
    input logic [fbef_pkg::CNT_W-1:0]   o_count
);
    import fbef_pkg::*;

    logic in_acc;
    assign in_acc = i_in_valid && !o_in_stall;

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_event_code) && $stable(o_count))
        else $error("stalled result changed");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> 32'(o_count) <= QUEUE_DEPTH)
        else $error("count above queue depth");

    a_query_clip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (i_op == OP_QUERY) |=>
            o_out_valid && (32'(o_count) <= 32'($past(i_max_count))))
        else $error("query count not clipped");

    a_code_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (i_op != OP_POP) |=> o_event_code == CODE_EMPTY)
        else $error("non-pop item returned a code");

endmodule

bind filtered_button_event_fifo fbef_checker u_fbef_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_stall   (o_in_stall),
    .i_op         (i_op),
    .i_max_count  (i_max_count),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_event_code (o_event_code),
    .o_count      (o_count)
);
